@@ hdl/swm_pkg.sv @@
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT  = 256;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int CFG_BITS            = 9;
   localparam int LEN_RESET           = 255;

   // width of one branch of the registered selection tree
   localparam int GROUP_SIZE = 16;

   // cycles from a result-giving beat until its median can be loaded
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   typedef struct packed {
      logic load;
      logic full;
   } ctrl_type;

   // zero acts as one, anything past the store saturates
   function automatic int clamp_len(input logic [CFG_BITS-1:0] raw, input int max_len);
      int v;
      v = int'(raw);
      if (v == 0) begin
         return 1;
      end
      if (v > max_len) begin
         return max_len;
      end
      return v;
   endfunction

endpackage

@@ hdl/swm_cell.sv @@
module swm_cell import swm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int INDEX       = 0,
   localparam int LEN_BITS   = $clog2(WINDOW_MAX + 1),
   localparam int AGE_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  logic                          clock,
   input  ctrl_type                      ctrl,
   input  logic signed [SAMPLE_BITS-1:0] key,
   input  logic signed [SAMPLE_BITS-1:0] old_key,
   input  logic        [LEN_BITS-1:0]    len_m1,
   input  logic        [LEN_BITS-1:0]    fill,
   input  logic signed [SAMPLE_BITS-1:0] left_b_val,
   input  logic        [AGE_BITS-1:0]    left_b_age,
   input  logic                          left_gb,
   input  logic signed [SAMPLE_BITS-1:0] right_val,
   input  logic        [AGE_BITS-1:0]    right_age,
   output logic signed [SAMPLE_BITS-1:0] cur_val,
   output logic        [AGE_BITS-1:0]    cur_age,
   output logic signed [SAMPLE_BITS-1:0] b_val,
   output logic        [AGE_BITS-1:0]    b_age,
   output logic                          gb
);

   logic signed [SAMPLE_BITS-1:0] val_ff, val_in;
   logic        [AGE_BITS-1:0]    age_ff, age_in;
   logic                          at_or_after_old;
   logic                          b_live;

   // among equal values the oldest sits first, so everything from the
   // removed entry rightward compares at or above it
   assign at_or_after_old = (val_ff >= old_key);

   // view of the window with the oldest entry taken out (or unchanged while filling)
   always_comb begin
      if (ctrl.full && at_or_after_old) begin
         b_val = right_val;
         b_age = right_age;
      end else begin
         b_val = val_ff;
         b_age = age_ff;
      end
      if (ctrl.full) begin
         b_live = (32'(INDEX) < 32'(len_m1));
      end else begin
         b_live = (32'(INDEX) < 32'(fill));
      end
      gb = !b_live || (b_val > key);
   end

   always_comb begin
      if (!gb) begin
         val_in = b_val;
         age_in = b_age + AGE_BITS'(1);
      end else if (INDEX == 0 || !left_gb) begin
         val_in = key;
         age_in = '0;
      end else begin
         val_in = left_b_val;
         age_in = left_b_age + AGE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign cur_val = val_ff;
   assign cur_age = age_ff;

endmodule

@@ hdl/swm_select.sv @@
module swm_select import swm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          match [WINDOW_MAX],
   input  logic signed [SAMPLE_BITS-1:0] vals  [WINDOW_MAX],
   output logic signed [SAMPLE_BITS-1:0] picked
);

   localparam int NGROUP = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [SAMPLE_BITS-1:0] grp_in [NGROUP];
   logic [SAMPLE_BITS-1:0] grp_ff [NGROUP];
   logic [SAMPLE_BITS-1:0] sel_in, sel_ff;

   // first level: OR of masked values inside each group
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < WINDOW_MAX) begin
               if (match[g * GROUP_SIZE + k]) begin
                  grp_in[g] = grp_in[g] | vals[g * GROUP_SIZE + k];
               end
            end
         end
      end
   end

   always_comb begin
      sel_in = '0;
      for (int g = 0; g < NGROUP; g++) begin
         sel_in = sel_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      sel_ff <= sel_in;
   end

   assign picked = $signed(sel_ff);

endmodule

@@ hdl/sliding_window_median_unit.sv @@
// Running median over the last window_length samples (csr_write_data, 1 up to
// WINDOW_MAX; 0 acts as 1, larger values saturate). Writing the length
// restarts the fill: the first window_length-1 samples give no result, and
// every sample after that gives the sorted entry at index window_length/2,
// the upper median for even lengths. The window lives in a row of cells kept
// in sorted order, each with the age of its sample; a new sample drops the
// oldest entry once the window is full and lands in its sorted place. A sample
// that gives no result leaves the input free for the next sample. One that
// gives a median holds the input until its median is loaded into the output
// register, after the two-level registered selection tree that picks the
// median and the oldest value out of the row has settled. While an earlier
// median beat is still stalled, the hold lasts until that beat is taken.
// There is no clearing pass after reset.
module sliding_window_median_unit import swm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_median,
   input  logic                          csr_write_enable,
   input  logic        [CFG_BITS-1:0]    csr_write_data
);

   localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
   localparam int AGE_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [LEN_BITS-1:0]           len_ff, len_in;
   logic [LEN_BITS-1:0]           fill_ff, fill_in;
   logic [LEN_BITS-1:0]           len_m1;
   logic [LEN_BITS-1:0]           fill_p1;
   logic [1:0]                    cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff;
   logic                          accept;
   logic                          full;
   logic                          has_result;
   logic                          out_free;
   logic                          load_out;
   ctrl_type                      ctrl;

   logic signed [SAMPLE_BITS-1:0] cur_val [WINDOW_MAX];
   logic        [AGE_BITS-1:0]    cur_age [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] b_val   [WINDOW_MAX];
   logic        [AGE_BITS-1:0]    b_age   [WINDOW_MAX];
   logic                          gb      [WINDOW_MAX];
   logic                          old_match [WINDOW_MAX];
   logic                          med_match [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] old_key;
   logic signed [SAMPLE_BITS-1:0] med_val;

   assign req_stall  = (cnt_ff != 2'd0);
   assign accept     = req_valid && !req_stall;
   assign full       = (fill_ff == len_ff);
   assign len_m1     = len_ff - LEN_BITS'(1);
   assign fill_p1    = fill_ff + LEN_BITS'(1);
   assign has_result = full || (fill_p1 == len_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_out   = (cnt_ff == 2'd1) && out_free;

   assign ctrl.load = accept;
   assign ctrl.full = full;

   genvar i;
   generate
      for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
         logic signed [SAMPLE_BITS-1:0] lb_val;
         logic        [AGE_BITS-1:0]    lb_age;
         logic                          lgb;
         logic signed [SAMPLE_BITS-1:0] r_val;
         logic        [AGE_BITS-1:0]    r_age;

         if (i == 0) begin : g_first
            assign lb_val = req_sample;
            assign lb_age = '0;
            assign lgb    = 1'b1;
         end else begin : g_inner_left
            assign lb_val = b_val[i-1];
            assign lb_age = b_age[i-1];
            assign lgb    = gb[i-1];
         end

         if (i == WINDOW_MAX - 1) begin : g_last
            assign r_val = cur_val[i];
            assign r_age = cur_age[i];
         end else begin : g_inner_right
            assign r_val = cur_val[i+1];
            assign r_age = cur_age[i+1];
         end

         swm_cell #(
            .WINDOW_MAX  (WINDOW_MAX),
            .SAMPLE_BITS (SAMPLE_BITS),
            .INDEX       (i)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .key        (req_sample),
            .old_key    (old_key),
            .len_m1     (len_m1),
            .fill       (fill_ff),
            .left_b_val (lb_val),
            .left_b_age (lb_age),
            .left_gb    (lgb),
            .right_val  (r_val),
            .right_age  (r_age),
            .cur_val    (cur_val[i]),
            .cur_age    (cur_age[i]),
            .b_val      (b_val[i]),
            .b_age      (b_age[i]),
            .gb         (gb[i])
         );
      end
   endgenerate

   // oldest entry and median position, picked out of the row
   always_comb begin
      for (int k = 0; k < WINDOW_MAX; k++) begin
         old_match[k] = (32'(k) < 32'(len_ff)) && (cur_age[k] == AGE_BITS'(len_m1));
         med_match[k] = (32'(k) == 32'(len_ff >> 1));
      end
   end

   swm_select #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_old_sel (
      .clock  (clock),
      .match  (old_match),
      .vals   (cur_val),
      .picked (old_key)
   );

   swm_select #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_med_sel (
      .clock  (clock),
      .match  (med_match),
      .vals   (cur_val),
      .picked (med_val)
   );

   always_comb begin
      len_in  = len_ff;
      fill_in = fill_ff;
      if (csr_write_enable) begin
         len_in  = LEN_BITS'(clamp_len(csr_write_data, WINDOW_MAX));
         fill_in = '0;
      end else if (accept && !full) begin
         fill_in = fill_p1;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept && has_result) begin
         cnt_in = SETTLE_CYCLES;
      end else if (cnt_ff > 2'd1) begin
         cnt_in = cnt_ff - 2'd1;
      end else if (load_out) begin
         cnt_in = 2'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_BITS'(clamp_len(CFG_BITS'(LEN_RESET), WINDOW_MAX));
         fill_ff      <= '0;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the median beat until it is taken
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_median_ff <= med_val;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

@@ tb/swm_median_checker.sv @@
module swm_median_checker import swm_pkg::*; #(
   parameter int WIN_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMP_W   = SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [SAMP_W-1:0] req_sample,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [SAMP_W-1:0] rsp_median,
   input  logic                     csr_write_enable,
   input  logic [CFG_BITS-1:0]      csr_write_data,
   output int                       medians_owed,
   output int                       fail_count
);

   localparam int PRINT_CAP = 50;

   logic signed [SAMP_W-1:0] by_value [WIN_MAX];
   logic signed [SAMP_W-1:0] by_age   [WIN_MAX];
   logic signed [SAMP_W-1:0] median_queue [$];
   logic signed [SAMP_W-1:0] want;
   int                       win_len;
   int                       held;
   int                       oldest;

   initial begin
      medians_owed = 0;
      fail_count   = 0;
   end

   function automatic int legal_length(input logic [CFG_BITS-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      return (int'(raw) > WIN_MAX) ? WIN_MAX : int'(raw);
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP) begin
         $display("MISMATCH: %s", msg);
      end
      fail_count++;
   endtask

   // fold one sample into the window; queue the median when the window is full
   task automatic absorb_sample(input logic signed [SAMP_W-1:0] s);
      logic signed [SAMP_W-1:0] gone;
      int                       i;
      if (held < win_len) begin
         i = held;
         while (i > 0 && by_value[i-1] > s) begin
            by_value[i] = by_value[i-1];
            i--;
         end
         by_value[i] = s;
         by_age[held] = s;
         held++;
         if (held < win_len) begin
            return;
         end
      end else begin
         gone = by_age[oldest];
         by_age[oldest] = s;
         oldest = (oldest + 1 == win_len) ? 0 : oldest + 1;
         i = 0;
         while (i < win_len - 1 && by_value[i] != gone) begin
            i++;
         end
         // open a hole where the evicted value sat, slide it to where s belongs
         while (i + 1 < win_len && by_value[i+1] < s) begin
            by_value[i] = by_value[i+1];
            i++;
         end
         while (i > 0 && by_value[i-1] > s) begin
            by_value[i] = by_value[i-1];
            i--;
         end
         by_value[i] = s;
      end
      median_queue.push_back(by_value[win_len / 2]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         win_len = legal_length(CFG_BITS'(LEN_RESET));
         held    = 0;
         oldest  = 0;
         median_queue.delete();
      end else begin
         if (csr_write_enable) begin
            win_len = legal_length(csr_write_data);
            held    = 0;
            oldest  = 0;
         end
         if (req_valid && !req_stall) begin
            absorb_sample(req_sample);
         end
         if (rsp_valid && !rsp_stall) begin
            if (median_queue.size() == 0) begin
               report_mismatch($sformatf("median %0d with none expected", rsp_median));
            end else begin
               want = median_queue.pop_front();
               if (rsp_median !== want) begin
                  report_mismatch($sformatf("median %0d, expected %0d", rsp_median, want));
               end
            end
         end
      end
      medians_owed <= median_queue.size();
   end

endmodule

@@ tb/tb_sliding_window_median_unit.sv @@
module tb_sliding_window_median_unit;
   import swm_pkg::*;

   localparam int SAMP_W      = SAMPLE_BITS_DEFAULT;
   localparam int IDLE_PCT    = 22;
   localparam int QUIET_WAIT  = 8;
   localparam int CYCLE_LIMIT = 200000;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic signed [SAMP_W-1:0] req_sample       = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [SAMP_W-1:0] rsp_median;
   logic                     csr_write_enable = 1'b0;
   logic [CFG_BITS-1:0]      csr_write_data   = '0;
   logic                     steady           = 1'b0;
   int                       medians_owed;
   int                       fail_count;

   sliding_window_median_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median       (rsp_median),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   swm_median_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median       (rsp_median),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .medians_owed     (medians_owed),
      .fail_count       (fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("sliding_window_median_unit verification failed");
      $finish;
   end

   // hold the beat until it is taken; random gaps go in front of it
   task automatic send_sample(input logic signed [SAMP_W-1:0] value);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // drain, let the pipe go quiet, then write the length
   task automatic write_length(input logic [CFG_BITS-1:0] raw);
      req_valid <= 1'b0;
      // let the owed count take in the last sample beat
      @(posedge clock);
      while (medians_owed != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_WAIT) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= raw;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // extremes, a narrow band that makes many ties, and full-range values
   function automatic logic signed [SAMP_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return SAMP_W'($urandom_range(0, 15)) - SAMP_W'(8);
         default: return SAMP_W'($urandom());
      endcase
   endfunction

   task automatic run_random(input logic [CFG_BITS-1:0] raw, input int count);
      write_length(raw);
      repeat (count) send_sample(pick_sample());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_length(9'd3);
      send_sample(16'h8000); send_sample(16'h7FFF); send_sample(16'h0000);
      send_sample(16'hFFFF); send_sample(16'h0001); send_sample(16'h7FFF);
      send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h8000);
      send_sample(16'h5555); send_sample(16'hAAAA);

      // zero acts as a window of one
      write_length(9'd0);
      send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'hFFFF);

      // even length picks the upper median
      write_length(9'd2);
      send_sample(16'd5); send_sample(16'd5); send_sample(-16'sd7);
      send_sample(16'd9); send_sample(16'h8000); send_sample(16'h7FFF);

      write_length(9'd1);
      send_sample(16'd0); send_sample(16'd12345);

      run_random(9'd255, 265);
      // past the store: saturates to the largest window
      run_random(9'h1FF, 265);
      for (int k = 0; k < 12; k++) begin
         steady <= (k == 3 || k == 4);
         run_random(CFG_BITS'($urandom_range(1, 24)), $urandom_range(20, 50));
      end
      steady <= 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (medians_owed != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("sliding_window_median_unit verification clean");
      end else begin
         $display("sliding_window_median_unit verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_select.sv
hdl/sliding_window_median_unit.sv
tb/swm_median_checker.sv
tb/tb_sliding_window_median_unit.sv
